// ===== design/dds_pkg.sv =====
// ----------------------------------------------------------------------------
// dds_pkg
// Shared widths, limits and interface types of the descriptive statistics block.
// ----------------------------------------------------------------------------
package dds_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int MAX_SAMPLES = 1024;
   localparam int ADDR_W      = 10;
   localparam int CNT_W       = 11;
   localparam int PTR_W       = 12;
   localparam int SUM_W       = 26;
   localparam int SQ_W        = 42;
   localparam int MAX_MODES   = 16;
   localparam int MODE_K_W    = 5;
   localparam int MED_W       = 17;
   localparam int MEAN_W      = 24;
   localparam int VAR_W       = 38;
   localparam int SD_W        = 24;
   localparam int DVD_W       = 61;
   localparam int DVS_W       = 21;
   localparam int RAD_W       = 46;
   localparam int ROOT_W      = 23;

   typedef struct packed {
      logic [CNT_W-1:0]    n;
      logic [SUM_W-1:0]    sum;
      logic [SQ_W-1:0]     sumsq;
      logic [SAMPLE_W-1:0] maxv;
      logic [SAMPLE_W-1:0] minv;
   } job_type;

   typedef struct packed {
      logic                we;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic job_pop;
      logic release_set;
   } back_ctl_type;

endpackage

// ===== design/dds_ram.sv =====
// ----------------------------------------------------------------------------
// dds_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module dds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

// ===== design/dds_div.sv =====
// ----------------------------------------------------------------------------
// dds_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dds_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [dds_pkg::DVD_W-1:0] dividend,
   input  logic [dds_pkg::DVS_W-1:0] divisor,
   output logic                      done,
   output logic [dds_pkg::DVD_W-1:0] quotient
);

   logic [dds_pkg::DVD_W-1:0] dvd_ff;
   logic [dds_pkg::DVS_W-1:0] dvs_ff;
   logic [dds_pkg::DVS_W-1:0] rem_ff;
   logic [5:0]                cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic [dds_pkg::DVS_W:0]   rem_sh;
   logic                      ge;
   logic [dds_pkg::DVS_W:0]   rem_sub;

   assign rem_sh  = {rem_ff, dvd_ff[dds_pkg::DVD_W-1]};
   assign ge      = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= ge ? rem_sub[dds_pkg::DVS_W-1:0] : rem_sh[dds_pkg::DVS_W-1:0];
            dvd_ff <= {dvd_ff[dds_pkg::DVD_W-2:0], ge};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(dds_pkg::DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ===== design/dds_sqrt.sv =====
// ----------------------------------------------------------------------------
// dds_sqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module dds_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [dds_pkg::RAD_W-1:0]  radicand,
   output logic                       done,
   output logic [dds_pkg::ROOT_W-1:0] root
);

   logic [dds_pkg::RAD_W-1:0]  rad_ff;
   logic [dds_pkg::ROOT_W:0]   rem_ff;
   logic [dds_pkg::ROOT_W-1:0] root_ff;
   logic [4:0]                 cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [dds_pkg::ROOT_W+2:0] rem_sh;
   logic [dds_pkg::ROOT_W+2:0] trial;
   logic                       ge;
   logic [dds_pkg::ROOT_W+2:0] rem_sub;

   assign rem_sh  = {rem_ff, rad_ff[dds_pkg::RAD_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign ge      = rem_sh >= trial;
   assign rem_sub = rem_sh - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff  <= ge ? rem_sub[dds_pkg::ROOT_W:0] : rem_sh[dds_pkg::ROOT_W:0];
            root_ff <= {root_ff[dds_pkg::ROOT_W-2:0], ge};
            rad_ff  <= {rad_ff[dds_pkg::RAD_W-3:0], 2'b00};
            cnt_ff  <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(dds_pkg::ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== design/dds_front.sv =====
// ----------------------------------------------------------------------------
// dds_front
// Takes samples, stores them, keeps running sums and extremes, and queues
// one job per closed set.
// ----------------------------------------------------------------------------
module dds_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [dds_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                         req_last_sample,
   output dds_pkg::ram_wr_type          wr,
   output logic                         job_valid,
   output dds_pkg::job_type             job,
   input  dds_pkg::back_ctl_type        ctl
);

   logic [dds_pkg::CNT_W-1:0]    cnt_ff,  cnt_in;
   logic [dds_pkg::SUM_W-1:0]    sum_ff,  sum_in;
   logic [dds_pkg::SQ_W-1:0]     sq_ff,   sq_in;
   logic [dds_pkg::SAMPLE_W-1:0] max_ff,  max_in;
   logic [dds_pkg::SAMPLE_W-1:0] min_ff,  min_in;
   logic                         held_ff;
   dds_pkg::job_type             q_ff [2];
   logic                         wp_ff;
   logic                         rp_ff;
   logic [1:0]                   qcnt_ff;
   logic                         accept;
   logic                         add;
   logic                         push;
   logic [2*dds_pkg::SAMPLE_W-1:0] sq;

   assign req_ready = !held_ff && (qcnt_ff != 2'd2);
   assign accept    = req_valid && req_ready;
   assign add       = accept && (cnt_ff < dds_pkg::CNT_W'(dds_pkg::MAX_SAMPLES));
   assign push      = accept && req_last_sample;
   assign sq        = req_sample * req_sample;

   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      sq_in  = sq_ff;
      max_in = max_ff;
      min_in = min_ff;
      if (add) begin
         cnt_in = cnt_ff + 1'b1;
         sum_in = sum_ff + dds_pkg::SUM_W'(req_sample);
         sq_in  = sq_ff + dds_pkg::SQ_W'(sq);
         if (req_sample > max_ff) max_in = req_sample;
         if (req_sample < min_ff) min_in = req_sample;
      end
   end

   assign wr.we   = add;
   assign wr.addr = cnt_ff[dds_pkg::ADDR_W-1:0];
   assign wr.data = req_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         sum_ff  <= '0;
         sq_ff   <= '0;
         max_ff  <= '0;
         min_ff  <= '1;
         held_ff <= 1'b0;
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         qcnt_ff <= '0;
      end else begin
         if (push) begin
            cnt_ff  <= '0;
            sum_ff  <= '0;
            sq_ff   <= '0;
            max_ff  <= '0;
            min_ff  <= '1;
            held_ff <= 1'b1;
            q_ff[wp_ff] <= '{n: cnt_in, sum: sum_in, sumsq: sq_in,
                             maxv: max_in, minv: min_in};
            wp_ff <= !wp_ff;
         end else begin
            cnt_ff <= cnt_in;
            sum_ff <= sum_in;
            sq_ff  <= sq_in;
            max_ff <= max_in;
            min_ff <= min_in;
            if (ctl.release_set) held_ff <= 1'b0;
         end
         if (ctl.job_pop) rp_ff <= !rp_ff;
         qcnt_ff <= qcnt_ff + 2'(push) - 2'(ctl.job_pop);
      end
   end

   assign job_valid = qcnt_ff != 2'd0;
   assign job       = q_ff[rp_ff];

endmodule

// ===== design/dds_back.sv =====
// ----------------------------------------------------------------------------
// dds_back
// Per-set work: merge sort between two RAMs, median, mean, variance,
// deviation and the two-pass mode scan that emits the results.
// ----------------------------------------------------------------------------
module dds_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  dds_pkg::job_type              job,
   output dds_pkg::back_ctl_type         ctl,
   output logic [dds_pkg::ADDR_W-1:0]    rd_addr_a,
   output logic [dds_pkg::ADDR_W-1:0]    rd_addr_b,
   input  logic [dds_pkg::SAMPLE_W-1:0]  rdata0_a,
   input  logic [dds_pkg::SAMPLE_W-1:0]  rdata0_b,
   input  logic [dds_pkg::SAMPLE_W-1:0]  rdata1_a,
   input  logic [dds_pkg::SAMPLE_W-1:0]  rdata1_b,
   output dds_pkg::ram_wr_type           wr0,
   output dds_pkg::ram_wr_type           wr1,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dds_pkg::SAMPLE_W-1:0]  rsp_max_value,
   output logic [dds_pkg::SAMPLE_W-1:0]  rsp_min_value,
   output logic [dds_pkg::MED_W-1:0]     rsp_median_doubled,
   output logic [dds_pkg::MEAN_W-1:0]    rsp_mean_q8,
   output logic [dds_pkg::VAR_W-1:0]     rsp_variance_q8,
   output logic [dds_pkg::SD_W-1:0]      rsp_stddev_q8,
   output logic [dds_pkg::SAMPLE_W-1:0]  rsp_mode_value,
   output logic [dds_pkg::CNT_W-1:0]     rsp_mode_count,
   output logic                          rsp_mode_last,
   output logic                          rsp_modes_truncated
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SORT_RD  = 4'd1;
   localparam logic [3:0] ST_SORT_WR  = 4'd2;
   localparam logic [3:0] ST_MED_RD   = 4'd3;
   localparam logic [3:0] ST_MED_GET  = 4'd4;
   localparam logic [3:0] ST_SUB      = 4'd5;
   localparam logic [3:0] ST_DIV_MEAN = 4'd6;
   localparam logic [3:0] ST_DIV_VAR  = 4'd7;
   localparam logic [3:0] ST_SQRT     = 4'd8;
   localparam logic [3:0] ST_SCAN_RD  = 4'd9;
   localparam logic [3:0] ST_SCAN_CMP = 4'd10;
   localparam logic [3:0] ST_SCAN_END = 4'd11;
   localparam logic [3:0] ST_SCAN_FIN = 4'd12;
   localparam logic [3:0] ST_DONE     = 4'd13;

   localparam int PTR_W = dds_pkg::PTR_W;
   localparam int SW    = dds_pkg::SAMPLE_W;
   localparam int CW    = dds_pkg::CNT_W;

   logic [3:0]                 state_ff;
   dds_pkg::job_type           job_ff;
   logic                       sel_ff;
   logic [PTR_W-1:0]           w_ff, base_ff, pa_ff, pb_ff, ea_ff, eb_ff, wi_ff;
   logic [dds_pkg::MED_W-1:0]  med_ff;
   logic [52:0]                p1_ff;
   logic [51:0]                p2_ff;
   logic [dds_pkg::DVS_W-1:0]  nn_ff;
   logic [52:0]                num_ff;
   logic [dds_pkg::MEAN_W-1:0] mean_ff;
   logic [dds_pkg::VAR_W-1:0]  var_ff;
   logic [dds_pkg::SD_W-1:0]   sd_ff;
   logic [CW-1:0]              idx_ff, len_ff, best_ff, modes_ff;
   logic [SW-1:0]              prev_ff;
   logic [dds_pkg::MODE_K_W-1:0] k_ff, emit_ff;
   logic                       trunc_ff;
   logic                       pass_ff;
   logic                       ov_ff;
   logic [SW-1:0]              o_mode_ff;
   logic [CW-1:0]              o_cnt_ff;
   logic                       o_last_ff;
   logic                       o_trunc_ff;
   logic [dds_pkg::MED_W-1:0]  o_med_ff;
   logic [dds_pkg::MEAN_W-1:0] o_mean_ff;
   logic [dds_pkg::VAR_W-1:0]  o_var_ff;
   logic [dds_pkg::SD_W-1:0]   o_sd_ff;
   logic [SW-1:0]              o_max_ff, o_min_ff;

   logic [SW-1:0]              src_a, src_b;
   logic                       take_a;
   logic [PTR_W-1:0]           n_ext, pa_nx, pb_nx, nbase, w2;
   logic                       blk_done;
   logic [PTR_W-1:0]           half;
   logic                       can_emit;
   logic                       load;
   logic [SW-1:0]              load_val;
   logic                       load_last;
   logic                       run_end;
   logic                       hit;
   logic                       div_start, div_done;
   logic [dds_pkg::DVD_W-1:0]  div_dvd, div_q;
   logic [dds_pkg::DVS_W-1:0]  div_dvs;
   logic                       sqrt_start, sqrt_done;
   logic [dds_pkg::ROOT_W-1:0] sqrt_root;

   function automatic logic [PTR_W-1:0] blk_end(input logic [PTR_W-1:0] b,
                                                 input logic [PTR_W-1:0] len,
                                                 input logic [PTR_W-1:0] n);
      logic [PTR_W:0] e;
      e = {1'b0, b} + {1'b0, len};
      return (e > {1'b0, n}) ? n : e[PTR_W-1:0];
   endfunction

   assign src_a    = sel_ff ? rdata1_a : rdata0_a;
   assign src_b    = sel_ff ? rdata1_b : rdata0_b;
   assign n_ext    = PTR_W'(job_ff.n);
   assign half     = n_ext >> 1;
   assign take_a   = (pa_ff < ea_ff) && ((pb_ff >= eb_ff) || (src_a <= src_b));
   assign pa_nx    = pa_ff + PTR_W'(take_a);
   assign pb_nx    = pb_ff + PTR_W'(!take_a);
   assign blk_done = (pa_nx == ea_ff) && (pb_nx == eb_ff);
   assign nbase    = base_ff + (w_ff << 1);
   assign w2       = w_ff << 1;

   always_comb begin
      if (state_ff == ST_SORT_RD || state_ff == ST_SORT_WR) begin
         rd_addr_a = pa_ff[dds_pkg::ADDR_W-1:0];
         rd_addr_b = pb_ff[dds_pkg::ADDR_W-1:0];
      end else if (state_ff == ST_MED_RD || state_ff == ST_MED_GET) begin
         rd_addr_a = dds_pkg::ADDR_W'(half - 1'b1);
         rd_addr_b = half[dds_pkg::ADDR_W-1:0];
      end else begin
         rd_addr_a = idx_ff[dds_pkg::ADDR_W-1:0];
         rd_addr_b = half[dds_pkg::ADDR_W-1:0];
      end
   end

   assign wr0.we   = (state_ff == ST_SORT_WR) && sel_ff;
   assign wr1.we   = (state_ff == ST_SORT_WR) && !sel_ff;
   assign wr0.addr = wi_ff[dds_pkg::ADDR_W-1:0];
   assign wr1.addr = wi_ff[dds_pkg::ADDR_W-1:0];
   assign wr0.data = take_a ? src_a : src_b;
   assign wr1.data = take_a ? src_a : src_b;

   assign run_end  = (idx_ff != '0) && (src_a != prev_ff);
   assign can_emit = !ov_ff || rsp_ready;
   assign hit      = pass_ff && (len_ff == best_ff) && (k_ff < emit_ff) &&
                     ((state_ff == ST_SCAN_CMP && run_end) || state_ff == ST_SCAN_END);
   assign load      = hit && can_emit;
   assign load_val  = prev_ff;
   assign load_last = (k_ff + 1'b1) == emit_ff;

   assign div_start = (state_ff == ST_SUB) || (state_ff == ST_DIV_MEAN && div_done);
   assign div_dvd   = (state_ff == ST_SUB) ?
                      dds_pkg::DVD_W'({job_ff.sum, 8'b0}) : {num_ff, 8'b0};
   assign div_dvs   = (state_ff == ST_SUB) ? dds_pkg::DVS_W'(job_ff.n) : nn_ff;
   assign sqrt_start = (state_ff == ST_DIV_VAR) && div_done;

   dds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   dds_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({div_q[dds_pkg::VAR_W-1:0], 8'b0}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign ctl.job_pop     = (state_ff == ST_IDLE) && job_valid;
   assign ctl.release_set = state_ff == ST_DONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         if (load) begin
            ov_ff <= 1'b1;
         end else if (rsp_ready) begin
            ov_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  job_ff  <= job;
                  sel_ff  <= 1'b0;
                  w_ff    <= PTR_W'(1);
                  base_ff <= '0;
                  pa_ff   <= '0;
                  wi_ff   <= '0;
                  pb_ff   <= blk_end('0, PTR_W'(1), PTR_W'(job.n));
                  ea_ff   <= blk_end('0, PTR_W'(1), PTR_W'(job.n));
                  eb_ff   <= blk_end('0, PTR_W'(2), PTR_W'(job.n));
                  state_ff <= (job.n < CW'(2)) ? ST_MED_RD : ST_SORT_RD;
               end
            end
            ST_SORT_RD: state_ff <= ST_SORT_WR;
            ST_SORT_WR: begin
               wi_ff    <= wi_ff + 1'b1;
               pa_ff    <= pa_nx;
               pb_ff    <= pb_nx;
               state_ff <= ST_SORT_RD;
               if (blk_done) begin
                  if (nbase >= n_ext) begin
                     sel_ff <= !sel_ff;
                     if (w2 >= n_ext) begin
                        state_ff <= ST_MED_RD;
                     end else begin
                        w_ff    <= w2;
                        base_ff <= '0;
                        wi_ff   <= '0;
                        pa_ff   <= '0;
                        pb_ff   <= blk_end('0, w2, n_ext);
                        ea_ff   <= blk_end('0, w2, n_ext);
                        eb_ff   <= blk_end('0, w2 << 1, n_ext);
                     end
                  end else begin
                     base_ff <= nbase;
                     pa_ff   <= nbase;
                     pb_ff   <= blk_end(nbase, w_ff, n_ext);
                     ea_ff   <= blk_end(nbase, w_ff, n_ext);
                     eb_ff   <= blk_end(nbase, w2, n_ext);
                  end
               end
            end
            ST_MED_RD: state_ff <= ST_MED_GET;
            ST_MED_GET: begin
               if (job_ff.n < CW'(2)) begin
                  med_ff <= '0;
               end else if (job_ff.n[0]) begin
                  med_ff <= {src_b, 1'b0};
               end else begin
                  med_ff <= dds_pkg::MED_W'(src_a) + dds_pkg::MED_W'(src_b);
               end
               p1_ff    <= 53'(job_ff.n) * 53'(job_ff.sumsq);
               p2_ff    <= 52'(job_ff.sum) * 52'(job_ff.sum);
               nn_ff    <= dds_pkg::DVS_W'(22'(job_ff.n) * 22'(job_ff.n));
               state_ff <= ST_SUB;
            end
            ST_SUB: begin
               num_ff   <= p1_ff - 53'(p2_ff);
               state_ff <= ST_DIV_MEAN;
            end
            ST_DIV_MEAN: begin
               if (div_done) begin
                  mean_ff  <= div_q[dds_pkg::MEAN_W-1:0];
                  state_ff <= ST_DIV_VAR;
               end
            end
            ST_DIV_VAR: begin
               if (div_done) begin
                  var_ff   <= div_q[dds_pkg::VAR_W-1:0];
                  state_ff <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               if (sqrt_done) begin
                  sd_ff    <= dds_pkg::SD_W'(sqrt_root);
                  pass_ff  <= 1'b0;
                  idx_ff   <= '0;
                  len_ff   <= '0;
                  best_ff  <= '0;
                  modes_ff <= '0;
                  k_ff     <= '0;
                  state_ff <= ST_SCAN_RD;
               end
            end
            ST_SCAN_RD: state_ff <= ST_SCAN_CMP;
            ST_SCAN_CMP: begin
               if (!hit || can_emit) begin
                  if (!pass_ff && run_end) begin
                     if (len_ff > best_ff) begin
                        best_ff  <= len_ff;
                        modes_ff <= CW'(1);
                     end else if (len_ff == best_ff) begin
                        modes_ff <= modes_ff + 1'b1;
                     end
                  end
                  if (load) k_ff <= k_ff + 1'b1;
                  prev_ff <= src_a;
                  len_ff  <= (run_end || idx_ff == '0) ? CW'(1) : len_ff + 1'b1;
                  idx_ff  <= idx_ff + 1'b1;
                  if (load && load_last) begin
                     state_ff <= ST_DONE;
                  end else if (idx_ff + 1'b1 == job_ff.n) begin
                     state_ff <= ST_SCAN_END;
                  end else begin
                     state_ff <= ST_SCAN_RD;
                  end
               end
            end
            ST_SCAN_END: begin
               if (!pass_ff) begin
                  if (len_ff > best_ff) begin
                     best_ff  <= len_ff;
                     modes_ff <= CW'(1);
                  end else if (len_ff == best_ff) begin
                     modes_ff <= modes_ff + 1'b1;
                  end
                  state_ff <= ST_SCAN_FIN;
               end else if (!hit || can_emit) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_SCAN_FIN: begin
               emit_ff  <= (modes_ff > CW'(dds_pkg::MAX_MODES)) ?
                           dds_pkg::MODE_K_W'(dds_pkg::MAX_MODES) :
                           dds_pkg::MODE_K_W'(modes_ff);
               trunc_ff <= modes_ff > CW'(dds_pkg::MAX_MODES);
               pass_ff  <= 1'b1;
               idx_ff   <= '0;
               len_ff   <= '0;
               state_ff <= ST_SCAN_RD;
            end
            ST_DONE: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         o_mode_ff  <= load_val;
         o_cnt_ff   <= best_ff;
         o_last_ff  <= load_last;
         o_trunc_ff <= trunc_ff;
         o_med_ff   <= med_ff;
         o_mean_ff  <= mean_ff;
         o_var_ff   <= var_ff;
         o_sd_ff    <= sd_ff;
         o_max_ff   <= job_ff.maxv;
         o_min_ff   <= job_ff.minv;
      end
   end

   assign rsp_valid           = ov_ff;
   assign rsp_max_value       = o_max_ff;
   assign rsp_min_value       = o_min_ff;
   assign rsp_median_doubled  = o_med_ff;
   assign rsp_mean_q8         = o_mean_ff;
   assign rsp_variance_q8     = o_var_ff;
   assign rsp_stddev_q8       = o_sd_ff;
   assign rsp_mode_value      = o_mode_ff;
   assign rsp_mode_count      = o_cnt_ff;
   assign rsp_mode_last       = o_last_ff;
   assign rsp_modes_truncated = o_trunc_ff;

endmodule

// ===== design/dataset_descriptive_statistics.sv =====
// ----------------------------------------------------------------------------
// dataset_descriptive_statistics
// Max, min, median, mean, variance, deviation and modes of a sample set.
// ----------------------------------------------------------------------------
// Samples load at one per cycle, up to 1024 per set. The request marked last
// closes the set; new samples are held off until its statistics are done.
// Set-end work for a set is a merge sort (each element read, then written,
// between two ping-ponged RAMs), division for mean and variance, the square
// root, and the two passes of the mode scan, plus any responder stall. One
// response per mode, at most 16.
module dataset_descriptive_statistics (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [dds_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                         req_last_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [dds_pkg::SAMPLE_W-1:0] rsp_max_value,
   output logic [dds_pkg::SAMPLE_W-1:0] rsp_min_value,
   output logic [dds_pkg::MED_W-1:0]    rsp_median_doubled,
   output logic [dds_pkg::MEAN_W-1:0]   rsp_mean_q8,
   output logic [dds_pkg::VAR_W-1:0]    rsp_variance_q8,
   output logic [dds_pkg::SD_W-1:0]     rsp_stddev_q8,
   output logic [dds_pkg::SAMPLE_W-1:0] rsp_mode_value,
   output logic [dds_pkg::CNT_W-1:0]    rsp_mode_count,
   output logic                         rsp_mode_last,
   output logic                         rsp_modes_truncated
);

   dds_pkg::ram_wr_type          front_wr, back_wr0, back_wr1, ram0_wr;
   logic                         job_valid;
   dds_pkg::job_type             job;
   dds_pkg::back_ctl_type        ctl;
   logic [dds_pkg::ADDR_W-1:0]   rd_addr_a, rd_addr_b;
   logic [dds_pkg::SAMPLE_W-1:0] rdata0_a, rdata0_b, rdata1_a, rdata1_b;

   assign ram0_wr = front_wr.we ? front_wr : back_wr0;

   dds_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .wr              (front_wr),
      .job_valid       (job_valid),
      .job             (job),
      .ctl             (ctl)
   );

   dds_ram #(.WIDTH(dds_pkg::SAMPLE_W), .DEPTH(dds_pkg::MAX_SAMPLES)) u_ram0 (
      .clock   (clock),
      .we      (ram0_wr.we),
      .waddr   (ram0_wr.addr),
      .wdata   (ram0_wr.data),
      .raddr_a (rd_addr_a),
      .raddr_b (rd_addr_b),
      .rdata_a (rdata0_a),
      .rdata_b (rdata0_b)
   );

   dds_ram #(.WIDTH(dds_pkg::SAMPLE_W), .DEPTH(dds_pkg::MAX_SAMPLES)) u_ram1 (
      .clock   (clock),
      .we      (back_wr1.we),
      .waddr   (back_wr1.addr),
      .wdata   (back_wr1.data),
      .raddr_a (rd_addr_a),
      .raddr_b (rd_addr_b),
      .rdata_a (rdata1_a),
      .rdata_b (rdata1_b)
   );

   dds_back u_back (
      .clock               (clock),
      .reset               (reset),
      .job_valid           (job_valid),
      .job                 (job),
      .ctl                 (ctl),
      .rd_addr_a           (rd_addr_a),
      .rd_addr_b           (rd_addr_b),
      .rdata0_a            (rdata0_a),
      .rdata0_b            (rdata0_b),
      .rdata1_a            (rdata1_a),
      .rdata1_b            (rdata1_b),
      .wr0                 (back_wr0),
      .wr1                 (back_wr1),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_max_value       (rsp_max_value),
      .rsp_min_value       (rsp_min_value),
      .rsp_median_doubled  (rsp_median_doubled),
      .rsp_mean_q8         (rsp_mean_q8),
      .rsp_variance_q8     (rsp_variance_q8),
      .rsp_stddev_q8       (rsp_stddev_q8),
      .rsp_mode_value      (rsp_mode_value),
      .rsp_mode_count      (rsp_mode_count),
      .rsp_mode_last       (rsp_mode_last),
      .rsp_modes_truncated (rsp_modes_truncated)
   );

endmodule

// ===== design/dds_checker.sv =====
// ----------------------------------------------------------------------------
// dds_checker
// Port-level checks on the statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module dds_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [dds_pkg::SAMPLE_W-1:0] rsp_max_value,
   input logic [dds_pkg::SAMPLE_W-1:0] rsp_min_value,
   input logic [dds_pkg::MED_W-1:0]    rsp_median_doubled,
   input logic [dds_pkg::SAMPLE_W-1:0] rsp_mode_value,
   input logic [dds_pkg::CNT_W-1:0]    rsp_mode_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode_value))
      else $error("response dropped or changed while stalled");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mode_count != '0)
      else $error("mode count of zero");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_min_value <= rsp_max_value)
      else $error("min above max");

   a_median_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_median_doubled <= {rsp_max_value, 1'b0})
      else $error("median above max");

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mode_value <= rsp_max_value && rsp_mode_value >= rsp_min_value)
      else $error("mode outside min and max");

endmodule

bind dataset_descriptive_statistics dds_checker u_dds_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_max_value      (rsp_max_value),
   .rsp_min_value      (rsp_min_value),
   .rsp_median_doubled (rsp_median_doubled),
   .rsp_mode_value     (rsp_mode_value),
   .rsp_mode_count     (rsp_mode_count)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks dataset_descriptive_statistics: sample sets are streamed in, each
// closed by a last request, and every response is compared with a predicted
// set of statistics and modes, in order and field by field.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [dds_pkg::SAMPLE_W-1:0] maxv;
      logic [dds_pkg::SAMPLE_W-1:0] minv;
      logic [dds_pkg::MED_W-1:0]    med;
      logic [dds_pkg::MEAN_W-1:0]   mean;
      logic [dds_pkg::VAR_W-1:0]    var_q8;
      logic [dds_pkg::SD_W-1:0]     sd;
      logic [dds_pkg::SAMPLE_W-1:0] mode_v;
      logic [dds_pkg::CNT_W-1:0]    mode_n;
      logic                         mode_last;
      logic                         trunc;
   } stats_type;

   typedef struct {
      logic [dds_pkg::SAMPLE_W-1:0] sample;
      logic                         last;
      logic                         typed;
      stats_type                    known;
   } row_type;

   localparam int WATCHDOG = 400000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, rsp_ready = 0;
   logic [dds_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic req_last_sample = 0;
   logic rsp_valid, req_ready;
   logic [dds_pkg::SAMPLE_W-1:0] rsp_max_value, rsp_min_value, rsp_mode_value;
   logic [dds_pkg::MED_W-1:0]    rsp_median_doubled;
   logic [dds_pkg::MEAN_W-1:0]   rsp_mean_q8;
   logic [dds_pkg::VAR_W-1:0]    rsp_variance_q8;
   logic [dds_pkg::SD_W-1:0]     rsp_stddev_q8;
   logic [dds_pkg::CNT_W-1:0]    rsp_mode_count;
   logic rsp_mode_last, rsp_modes_truncated;

   dataset_descriptive_statistics u_dut (.*);

   initial forever #5 clock = ~clock;

   stats_type pending_stats[$];
   logic [dds_pkg::SAMPLE_W-1:0] held_samples[$];
   row_type stim_rows[$];
   int mismatches = 0, sets_closed = 0, requests = 0, responses = 0;
   int idle_count = 0;
   bit no_idle = 0;

   function automatic void expect_stats(input stats_type e);
      pending_stats.insert(pending_stats.size(), e);
   endfunction

   function automatic void hold_sample(input logic [dds_pkg::SAMPLE_W-1:0] smp);
      held_samples.insert(held_samples.size(), smp);
   endfunction

   function automatic void add_row(input row_type r);
      stim_rows.insert(stim_rows.size(), r);
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   // Close the held set: one expected response per mode, at most MAX_MODES.
   task automatic predict_stats();
      logic [dds_pkg::SAMPLE_W-1:0] s[$];
      longint unsigned n, sum = 0, sq = 0, num, v;
      stats_type e;
      int best = 0, modes = 0, emit, k = 0, i, j;
      s = held_samples;
      s.sort();
      n = s.size();
      foreach (s[x]) begin
         sum += s[x];
         sq += longint'(s[x]) * s[x];
      end
      e.maxv = s[n-1];
      e.minv = s[0];
      e.med = n < 2 ? 0 : (n % 2) ? 2 * s[n/2] : s[n/2-1] + s[n/2];
      e.mean = (sum << 8) / n;
      num = n * sq - sum * sum;
      v = (num << 8) / (n * n);
      e.var_q8 = v;
      e.sd = int_sqrt(v << 8);
      for (i = 0; i < n; i = j) begin
         for (j = i; j < n && s[j] == s[i]; j++);
         if (j - i > best) begin best = j - i; modes = 1; end
         else if (j - i == best) modes++;
      end
      emit = modes > dds_pkg::MAX_MODES ? dds_pkg::MAX_MODES : modes;
      e.mode_n = best;
      e.trunc = modes > dds_pkg::MAX_MODES;
      for (i = 0; i < n && k < emit; i = j) begin
         for (j = i; j < n && s[j] == s[i]; j++);
         if (j - i == best) begin
            e.mode_v = s[i];
            e.mode_last = (k + 1 == emit);
            expect_stats(e);
            k++;
         end
      end
      held_samples.delete();
      sets_closed++;
   endtask

   task automatic send(input logic [dds_pkg::SAMPLE_W-1:0] smp, input logic last);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1;
      req_sample <= smp;
      req_last_sample <= last;
      do @(posedge clock); while (!req_ready);
      requests++;
      if (held_samples.size() < dds_pkg::MAX_SAMPLES) hold_sample(smp);
      if (last) predict_stats();
   endtask

   task automatic drop_valid();
      req_valid <= 0;
      req_last_sample <= 0;
   endtask

   task automatic wait_drained();
      while (pending_stats.size() != 0) @(posedge clock);
   endtask

   // Response side: random stall bursts and compare.
   initial begin
      stats_type e;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            responses++;
            if (pending_stats.size() == 0) report("unexpected response", 0, 0);
            else begin
               e = pending_stats.pop_front();
               if (rsp_max_value != e.maxv) report("max", rsp_max_value, e.maxv);
               if (rsp_min_value != e.minv) report("min", rsp_min_value, e.minv);
               if (rsp_median_doubled != e.med) report("median", rsp_median_doubled, e.med);
               if (rsp_mean_q8 != e.mean) report("mean", rsp_mean_q8, e.mean);
               if (rsp_variance_q8 != e.var_q8) report("variance", rsp_variance_q8, e.var_q8);
               if (rsp_stddev_q8 != e.sd) report("stddev", rsp_stddev_q8, e.sd);
               if (rsp_mode_value != e.mode_v) report("mode value", rsp_mode_value, e.mode_v);
               if (rsp_mode_count != e.mode_n) report("mode count", rsp_mode_count, e.mode_n);
               if (rsp_mode_last != e.mode_last) report("mode last", rsp_mode_last, e.mode_last);
               if (rsp_modes_truncated != e.trunc)
                  report("truncated", rsp_modes_truncated, e.trunc);
            end
         end
         if (!no_idle && rsp_ready && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_ready <= 1;
      end
   end

   // Watchdog on cycles without any handshake.
   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_count = 0;
         else idle_count++;
         if (idle_count >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic row_type mk(input logic [dds_pkg::SAMPLE_W-1:0] smp, input logic last);
      row_type r;
      r.sample = smp;
      r.last = last;
      r.typed = 0;
      r.known = '0;
      return r;
   endfunction

   function automatic row_type mk_known(input logic [dds_pkg::SAMPLE_W-1:0] smp,
                                        input stats_type k);
      row_type r = mk(smp, 1);
      r.typed = 1;
      r.known = k;
      return r;
   endfunction

   initial begin
      int n, kind, i, len;
      logic [dds_pkg::SAMPLE_W-1:0] v;
      logic [dds_pkg::SAMPLE_W-1:0] pool[4];

      // single-sample sets: median 0, zero variance
      add_row(mk_known(16'hFFFF, '{16'hFFFF, 16'hFFFF, 0, 24'hFFFF00, 0, 0,
                                  16'hFFFF, 1, 1, 0}));
      add_row(mk_known(16'h0000, '{0, 0, 0, 0, 0, 0, 0, 1, 1, 0}));
      // extremes: 0 and 65535
      add_row(mk(16'h0000, 0));
      add_row(mk(16'hFFFF, 1));
      // odd set with a single repeated mode
      add_row(mk(16'd7, 0));
      add_row(mk(16'd3, 0));
      add_row(mk(16'd7, 1));
      // all values distinct and unsorted: several modes
      foreach (pool[x]) pool[x] = 16'($urandom);
      for (i = 0; i < 4; i++) add_row(mk(pool[i] ^ 16'h5A5A, 0));
      add_row(mk(16'h1234, 1));
      // 18 distinct values: modes truncated
      for (i = 0; i < 17; i++) add_row(mk(16'(i * 3851), 0));
      add_row(mk(16'hAAAA, 1));

      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (stim_rows[r]) begin
         if (stim_rows[r].typed) begin
            drop_valid();
            @(posedge clock);
            wait_drained();
            send(stim_rows[r].sample, 1);
            pending_stats[0] = stim_rows[r].known;
         end else send(stim_rows[r].sample, stim_rows[r].last);
      end
      drop_valid();
      wait_drained();

      // random sets: mostly small, with value pools so modes repeat
      n = 0;
      while (n < 200) begin
         len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
         kind = $urandom_range(0, 2);
         foreach (pool[x]) pool[x] = 16'($urandom);
         if (n > 150) no_idle = 1;
         for (i = 0; i < len; i++) begin
            v = kind == 0 ? 16'($urandom) : kind == 1 ? pool[$urandom_range(0, 3)]
                : 16'($urandom_range(0, 3) * 16'h5555);
            send(v, i == len - 1);
            n++;
         end
         if ($urandom_range(0, 7) == 0) begin
            drop_valid();
            wait_drained();
         end
      end
      drop_valid();
      wait_drained();
      repeat (200) @(posedge clock);

      $display("Covered %0d requests in %0d sets, %0d responses checked",
               requests, sets_closed, responses);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
